/* design/sjisf_pkg.sv */
`default_nettype none

package sjisf_pkg;

	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_SLASH  = 3'd1;
	localparam logic [2:0] MODE_LINE   = 3'd2;
	localparam logic [2:0] MODE_BLOCK  = 3'd3;
	localparam logic [2:0] MODE_STAR   = 3'd4;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_SLASH = 2'd1;
	localparam logic [1:0] ERR_BLOCK = 2'd2;

	localparam logic [7:0] LEAD_SYM   = 8'h81;
	localparam logic [7:0] LEAD_DIGIT = 8'h82;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [7:0] DIGIT_LO = 8'h4F;
	localparam logic [7:0] DIGIT_HI = 8'h58;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} byte_req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       end_seen;
		logic [1:0] error_code;
		logic       last;
	} char_res_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       pending;
		logic       kind;
		logic [1:0] err;
	} scan_state_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       emit;
		logic [7:0] ch;
		logic [1:0] err;
	} scan_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} fold_t;

	typedef struct packed {
		logic [1:0] count;
		char_res_t  r0;
		char_res_t  r1;
	} step_out_t;

	function automatic fold_t fold_pair(logic kind, logic [7:0] b);
		fold_t f;
		f.hit = 1'b1;
		f.ch = 8'h00;
		if (!kind) begin
			case (b)
				8'h67, 8'h68: f.ch = 8'h22;
				8'h69: f.ch = 8'h28;
				8'h6A: f.ch = 8'h29;
				8'h6F: f.ch = 8'h7B;
				8'h70: f.ch = 8'h7D;
				8'h7B: f.ch = 8'h2B;
				8'h7C: f.ch = 8'h2D;
				8'h94: f.ch = 8'h23;
				8'hF3: f.ch = 8'h2D;
				default: f.hit = 1'b0;
			endcase
		end else if (b >= DIGIT_LO && b <= DIGIT_HI) begin
			f.ch = CH_ZERO + (b - DIGIT_LO);
		end else begin
			f.hit = 1'b0;
		end
		return f;
	endfunction

	function automatic scan_t scan_sym(logic [2:0] mode, logic [7:0] c);
		scan_t s;
		s.mode = mode;
		s.emit = 1'b0;
		s.ch = 8'h00;
		s.err = ERR_NONE;
		case (mode)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					s.mode = MODE_LINE;
				end else if (c == CH_STAR) begin
					s.mode = MODE_BLOCK;
				end else begin
					s.emit = 1'b1;
					s.err = ERR_SLASH;
				end
			end
			MODE_LINE: begin
				if (c == CH_LF) begin
					s.mode = MODE_NORMAL;
				end
			end
			MODE_BLOCK: begin
				if (c == CH_STAR) begin
					s.mode = MODE_STAR;
				end
			end
			MODE_STAR: begin
				if (c == CH_SLASH) begin
					s.mode = MODE_NORMAL;
				end else if (c != CH_STAR) begin
					s.mode = MODE_BLOCK;
				end
			end
			default: begin
				s.mode = MODE_NORMAL;
				if (c <= CH_SPACE) begin
					s.mode = MODE_NORMAL;
				end else if (c == CH_SEMI) begin
					s.mode = MODE_LINE;
				end else if (c == CH_SLASH) begin
					s.mode = MODE_SLASH;
				end else begin
					s.emit = 1'b1;
					s.ch = c;
				end
			end
		endcase
		return s;
	endfunction

	function automatic char_res_t to_res(scan_t s);
		char_res_t r;
		r.out_char = (s.err != ERR_NONE) ? 8'h00 : s.ch;
		r.end_seen = 1'b0;
		r.error_code = s.err;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/sjisf_step.sv */
`default_nettype none

module sjisf_step (
	input  wire sjisf_pkg::scan_state_t cur,
	input  wire sjisf_pkg::byte_req_t   req,
	output sjisf_pkg::scan_state_t      nxt,
	output sjisf_pkg::step_out_t        res
);

	logic [7:0]            lead;
	logic                  b_is_lead;
	sjisf_pkg::fold_t      fo;
	sjisf_pkg::scan_t      sl;
	sjisf_pkg::scan_t      sf;
	sjisf_pkg::scan_t      sb0;
	sjisf_pkg::scan_t      sb1;
	sjisf_pkg::scan_t      first;
	logic                  av;
	logic                  cv;
	sjisf_pkg::char_res_t  a;
	sjisf_pkg::char_res_t  c;

	assign lead = cur.kind ? sjisf_pkg::LEAD_DIGIT : sjisf_pkg::LEAD_SYM;
	assign b_is_lead = (req.data_byte == sjisf_pkg::LEAD_SYM)
		|| (req.data_byte == sjisf_pkg::LEAD_DIGIT);
	assign fo = sjisf_pkg::fold_pair(cur.kind, req.data_byte);
	assign sl = sjisf_pkg::scan_sym(cur.mode, lead);
	assign sf = sjisf_pkg::scan_sym(cur.mode, fo.ch);
	assign sb0 = sjisf_pkg::scan_sym(cur.mode, req.data_byte);
	assign sb1 = sjisf_pkg::scan_sym(sl.mode, req.data_byte);

	always_comb begin
		nxt = cur;
		av = 1'b0;
		cv = 1'b0;
		a = '0;
		c = '0;
		first = '0;
		if (cur.err != sjisf_pkg::ERR_NONE) begin
			av = 1'b1;
			a.error_code = cur.err;
		end else if (req.end_of_text) begin
			nxt.pending = 1'b0;
			if (cur.pending) begin
				first = sl;
			end else begin
				first.mode = cur.mode;
			end
			av = first.emit;
			a = sjisf_pkg::to_res(first);
			nxt.mode = first.mode;
			nxt.err = first.err;
			if (first.err == sjisf_pkg::ERR_NONE) begin
				cv = 1'b1;
				if (first.mode == sjisf_pkg::MODE_SLASH) begin
					c.error_code = sjisf_pkg::ERR_SLASH;
					nxt.err = sjisf_pkg::ERR_SLASH;
				end else if (first.mode == sjisf_pkg::MODE_BLOCK
					|| first.mode == sjisf_pkg::MODE_STAR) begin
					c.error_code = sjisf_pkg::ERR_BLOCK;
					nxt.err = sjisf_pkg::ERR_BLOCK;
				end else begin
					c.end_seen = 1'b1;
					nxt.mode = sjisf_pkg::MODE_NORMAL;
				end
			end
		end else if (cur.pending) begin
			nxt.pending = 1'b0;
			if (fo.hit) begin
				av = sf.emit;
				a = sjisf_pkg::to_res(sf);
				nxt.mode = sf.mode;
				nxt.err = sf.err;
			end else begin
				av = sl.emit;
				a = sjisf_pkg::to_res(sl);
				nxt.mode = sl.mode;
				nxt.err = sl.err;
				if (sl.err == sjisf_pkg::ERR_NONE) begin
					if (b_is_lead) begin
						nxt.pending = 1'b1;
						nxt.kind = (req.data_byte == sjisf_pkg::LEAD_DIGIT);
					end else begin
						cv = sb1.emit;
						c = sjisf_pkg::to_res(sb1);
						nxt.mode = sb1.mode;
						nxt.err = sb1.err;
					end
				end
			end
		end else if (b_is_lead) begin
			nxt.pending = 1'b1;
			nxt.kind = (req.data_byte == sjisf_pkg::LEAD_DIGIT);
		end else begin
			av = sb0.emit;
			a = sjisf_pkg::to_res(sb0);
			nxt.mode = sb0.mode;
			nxt.err = sb0.err;
		end
	end

	always_comb begin
		res.r0 = av ? a : c;
		res.r1 = c;
		res.count = {1'b0, av} + {1'b0, cv};
		res.r0.last = !(av && cv);
		res.r1.last = 1'b1;
	end

endmodule

`default_nettype wire

/* design/sjis_fold_comment_strip_filter_unit.sv */
// Results are registered: a result appears in the cycle after the byte request that causes it is taken.
// Throughput: one byte per cycle while each byte yields at most one result and char_ready
// is high; a byte that yields two results holds off the next byte until the two-entry
// result buffer has drained, one result per cycle.
// Reset: arst_n clears the scan state and any latched error, and empties the result buffer.
`default_nettype none

module sjis_fold_comment_strip_filter_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        byte_valid,
	output logic                       byte_ready,
	input  wire sjisf_pkg::byte_req_t  byte_data,
	output logic                       char_valid,
	input  wire                        char_ready,
	output sjisf_pkg::char_res_t       char_data
);

	sjisf_pkg::scan_state_t state_q;
	sjisf_pkg::scan_state_t state_nxt;
	sjisf_pkg::step_out_t   step;
	sjisf_pkg::char_res_t   slot0_q;
	sjisf_pkg::char_res_t   slot1_q;
	logic [1:0]             count_q;
	logic                   push;
	logic                   pop;
	logic [1:0]             count_left;

	sjisf_step u_step (
		.cur (state_q),
		.req (byte_data),
		.nxt (state_nxt),
		.res (step)
	);

	assign pop = char_valid && char_ready;
	assign count_left = count_q - {1'b0, pop};
	assign byte_ready = (count_left == 2'd0);
	assign push = byte_valid && byte_ready;
	assign char_valid = (count_q != 2'd0);
	assign char_data = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				state_q <= state_nxt;
				count_q <= step.count;
			end else begin
				count_q <= count_left;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= step.r0;
			slot1_q <= step.r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

`default_nettype wire
